// ===== hw/rtl/pck_pkg.sv =====
package pck_pkg;

    // default and limit of the largest total handled
    localparam int MAX_TOTAL_DEF = 127;

    // field widths
    localparam int W_IN  = 7;
    localparam int W_CNT = 32;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    // controls common to every cell of the chain
    typedef struct packed {
        logic run;    // shift both chains one place
        logic load;   // seed the ring and empty the delay line
        logic clear;  // empty the delay line at the end of a pass
    } t_cell_ctl;

    // controls from the sequencer to the datapath
    typedef struct packed {
        t_cell_ctl chain;
        logic      capture;   // take the head sum as the result
        logic      sc_load;   // take a shortcut result
        logic      sc_one;    // shortcut result is one rather than zero
        logic      out_load;  // move the result into the output register
    } t_dp_ctl;

endpackage

// ===== hw/rtl/pck_cell.sv =====
module pck_cell
    import pck_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_seed,
    input  logic             i_ins,
    input  logic [W_CNT-1:0] i_ring,
    input  logic [W_CNT-1:0] i_dly,
    input  logic [W_CNT-1:0] i_new,
    output logic [W_CNT-1:0] o_ring,
    output logic [W_CNT-1:0] o_dly
);

    logic [W_CNT-1:0] r_ring;
    logic [W_CNT-1:0] r_dly;

    // ring stage: holds one count of the previous pass, moves towards the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ring <= {{(W_CNT-1){1'b0}}, i_seed};
        end else if (i_ctl.run) begin
            r_ring <= i_ring;
        end
    end

    // delay stage: new counts enter at the insertion cell and walk to the end
    always_ff @(posedge i_clk) begin
        if (i_ctl.load || i_ctl.clear) begin
            r_dly <= '0;
        end else if (i_ctl.run) begin
            r_dly <= i_ins ? i_new : i_dly;
        end
    end

    assign o_ring = r_ring;
    assign o_dly  = r_dly;

endmodule

// ===== hw/rtl/pck_ctrl.sv =====
module pck_ctrl
    import pck_pkg::*;
#(
    parameter  int MAX_TOTAL = MAX_TOTAL_DEF,
    localparam int RL        = MAX_TOTAL + 1,
    localparam int IW        = $clog2(RL)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [W_IN-1:0] i_total,
    input  logic [W_IN-1:0] i_part_count,
    output logic            o_valid,
    input  logic            i_stall,
    output t_dp_ctl         o_ctl,
    output logic [IW-1:0]   o_ins_pos
);

    localparam logic [IW:0] RL_C = (IW+1)'(RL);

    t_state r_state, n_state;
    logic [IW-1:0] r_d, n_d;
    logic [IW-1:0] r_stage, n_stage;
    logic [IW-1:0] r_k, r_m;
    logic          r_out_valid, n_out_valid;

    logic accept, over, shortcut, sc_one, last, final_pass, slot_free;
    logic [W_IN-1:0] diff;

    // shortcut decode on the incoming request
    always_comb begin
        over     = i_total > W_IN'(MAX_TOTAL);
        shortcut = over || (i_part_count > i_total) || (i_part_count == W_IN'(1))
                   || (i_part_count == i_total) || (i_part_count == '0);
        sc_one   = !over && !(i_part_count > i_total)
                   && ((i_part_count == W_IN'(1)) || (i_part_count == i_total));
        diff     = i_total - i_part_count;
    end

    assign accept     = (r_state == ST_IDLE) && i_valid;
    assign last       = (r_d == IW'(RL - 1));
    assign final_pass = (r_stage == r_k);
    assign slot_free  = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = shortcut ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last && final_pass) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_ctl.sc_load    = shortcut;
                    o_ctl.sc_one     = sc_one;
                    o_ctl.chain.load = !shortcut;
                end
            end
            ST_RUN: begin
                o_ctl.chain.run   = 1'b1;
                o_ctl.chain.clear = last;
                o_ctl.capture     = final_pass && (r_d == r_m);
            end
            ST_HOLD: begin
                o_ctl.out_load = slot_free;
            end
            default: o_ctl = '0;
        endcase
    end

    // position and pass counters
    always_comb begin
        n_d     = r_d;
        n_stage = r_stage;
        if (accept) begin
            n_d     = '0;
            n_stage = IW'(1);
        end else if (r_state == ST_RUN) begin
            n_d = last ? '0 : r_d + IW'(1);
            if (last) begin
                n_stage = r_stage + IW'(1);
            end
        end
    end

    // output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_d         <= '0;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_d         <= n_d;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    // request operands, only used on the full path where both fit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_k <= IW'(i_part_count);
            r_m <= IW'(diff);
        end
    end

    // a new count of part size j enters the delay line j cells before its end
    assign o_ins_pos = IW'(RL_C - {1'b0, r_stage});
    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_out_valid;

endmodule

// ===== hw/rtl/partition_count_k_parts_core.sv =====
// Counts the partitions of i_total into exactly i_part_count positive parts,
// using p(n,k) = q(n-k,k), where q(d,j) counts partitions of d into parts no
// larger than j. A ring of MAX_TOTAL+1 cells holds q(.,j-1); one pass around
// the ring adds q(d-j,j), taken from a delay line inside the same cells, to
// build q(.,j). A request takes k passes around the ring; the shortcut cases
// k > n, k = 0, k = 1 and k = n (and totals above MAX_TOTAL) are answered
// without any pass. One request is worked at a time; the next is taken once
// the result has moved to the output register.
module partition_count_k_parts_core
    import pck_pkg::*;
#(
    parameter int MAX_TOTAL = MAX_TOTAL_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [W_IN-1:0]  i_total,
    input  logic [W_IN-1:0]  i_part_count,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [W_CNT-1:0] o_partition_count
);

    localparam int RL = MAX_TOTAL + 1;
    localparam int IW = $clog2(RL);

    t_dp_ctl          ctl;
    logic [IW-1:0]    ins_pos;
    logic [W_CNT-1:0] ring_out [RL];
    logic [W_CNT-1:0] dly_out  [RL];
    logic [W_CNT-1:0] head_sum;
    logic [W_CNT-1:0] r_res;
    logic [W_CNT-1:0] r_out;

    pck_ctrl #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_total      (i_total),
        .i_part_count (i_part_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ctl        (ctl),
        .o_ins_pos    (ins_pos)
    );

    // head of the chain: q(d,j) = q(d,j-1) + q(d-j,j)
    assign head_sum = ring_out[0] + dly_out[RL-1];

    // chain of cells
    for (genvar x = 0; x < RL; x++) begin : g_cell
        logic [W_CNT-1:0] ring_in;
        logic [W_CNT-1:0] dly_in;

        if (x == RL - 1) begin : g_tail
            assign ring_in = head_sum;
        end else begin : g_mid
            assign ring_in = ring_out[x+1];
        end

        if (x == 0) begin : g_first
            assign dly_in = '0;
        end else begin : g_next
            assign dly_in = dly_out[x-1];
        end

        pck_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl.chain),
            .i_seed (x == 0),
            .i_ins  (ins_pos == IW'(x)),
            .i_ring (ring_in),
            .i_dly  (dly_in),
            .i_new  (head_sum),
            .o_ring (ring_out[x]),
            .o_dly  (dly_out[x])
        );
    end

    // result register: shortcut value or count captured on the final pass
    always_ff @(posedge i_clk) begin
        if (ctl.sc_load) begin
            r_res <= {{(W_CNT-1){1'b0}}, ctl.sc_one};
        end else if (ctl.capture) begin
            r_res <= head_sum;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_partition_count = r_out;

endmodule

// ===== dv/partition_count_k_parts_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts the partition count of every accepted
// request and compares each returned count with the oldest one waiting.
module partition_count_k_parts_checker
    import pck_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_stall,
    input  logic [W_IN-1:0]  i_total,
    input  logic [W_IN-1:0]  i_part_count,
    input  logic             i_res_valid,
    input  logic             i_res_stall,
    input  logic [W_CNT-1:0] i_partition_count,
    output int               o_error_count,
    output int               o_outstanding
);

    typedef struct packed {
        logic [W_IN-1:0]  total;
        logic [W_IN-1:0]  part_count;
        logic [W_CNT-1:0] count;
    } t_awaited_count;

    // scratch table: ways[i][j] = partitions of i into exactly j parts
    logic [W_CNT-1:0] ways [0:MAX_TOTAL_DEF][0:MAX_TOTAL_DEF];

    t_awaited_count awaited_counts [$];
    t_awaited_count head;
    int             error_tally = 0;
    int             waiting     = 0;

    assign o_error_count = error_tally;
    assign o_outstanding = waiting;

    // p(i,j) = p(i-1,j-1) + p(i-j,j), seeded with p(0,0) = 1; untouched cells are zero
    function automatic logic [W_CNT-1:0] partitions_into_parts(input int n, input int k);
        int reach;
        for (int i = 0; i <= n; i++) begin
            for (int j = 0; j <= MAX_TOTAL_DEF; j++) begin
                ways[i][j] = '0;
            end
        end
        ways[0][0] = 1;
        for (int i = 1; i <= n; i++) begin
            reach = (k < i) ? k : i;
            for (int j = 1; j <= reach; j++) begin
                ways[i][j] = ways[i-1][j-1] + ways[i-j][j];
            end
        end
        return ways[n][k];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_tally++;
    endtask

    // result side first, so a count never pairs with a request taken at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_counts.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (awaited_counts.size() == 0) begin
                    report_mismatch($sformatf("unexpected count %0d", i_partition_count));
                end else begin
                    head = awaited_counts.pop_front();
                    if (i_partition_count !== head.count) begin
                        report_mismatch($sformatf("p(%0d,%0d): got %0d, want %0d",
                            head.total, head.part_count, i_partition_count, head.count));
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                head.total      = i_total;
                head.part_count = i_part_count;
                head.count      = partitions_into_parts(int'(i_total), int'(i_part_count));
                awaited_counts  = {awaited_counts, head};
            end
        end
        waiting <= awaited_counts.size();
    end

endmodule

// ===== dv/partition_count_k_parts_core_tb.sv =====
`timescale 1ns / 100ps

module partition_count_k_parts_core_tb;
    import pck_pkg::*;

    // bound on the whole run, kept wide to allow for long requests and stalls
    localparam int CYCLE_LIMIT      = 10_000_000;
    localparam int RANDOM_PER_PHASE = 25;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic [W_IN-1:0]  i_total      = '0;
    logic [W_IN-1:0]  i_part_count = '0;
    logic             i_stall      = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [W_CNT-1:0] o_partition_count;

    int          gap_pct     = 0;
    int          stall_pct   = 0;
    int          error_count;
    int          outstanding;
    int unsigned cycle_count = 0;

    partition_count_k_parts_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_total           (i_total),
        .i_part_count      (i_part_count),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_partition_count (o_partition_count)
    );

    partition_count_k_parts_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_valid),
        .i_req_stall       (o_stall),
        .i_total           (i_total),
        .i_part_count      (i_part_count),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_partition_count (o_partition_count),
        .o_error_count     (error_count),
        .o_outstanding     (outstanding)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // optional idle gap, then hold the request until it is taken
    task automatic send_request(input int n, input int k);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_total      <= W_IN'(n);
        i_part_count <= W_IN'(k);
        do @(posedge i_clk); while (o_stall);
    endtask

    // sender goes quiet until every count is back
    task automatic wait_for_results;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // mostly small part counts (each part costs a full pass), some shortcuts, a few large
    task automatic send_random_request;
        int n;
        int k;
        int pick;
        pick = $urandom_range(99);
        n    = $urandom_range(127);
        if (pick < 3) begin
            k = $urandom_range(127, 64);
            n = $urandom_range(127, k);
        end else if (pick < 15) begin
            case ($urandom_range(3))
                0: k = 0;
                1: k = 1;
                2: k = n;
                default: k = (n < 127) ? $urandom_range(127, n + 1) : 127;
            endcase
        end else begin
            k = $urandom_range(8, 2);
        end
        send_request(n, k);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty partition and zero parts
        send_request(0, 0);
        send_request(5, 0);
        send_request(127, 0);
        // more parts than the total
        send_request(0, 1);
        send_request(0, 127);
        send_request(3, 4);
        send_request(126, 127);
        // single part and all-ones shortcuts
        send_request(1, 1);
        send_request(127, 1);
        send_request(127, 127);
        send_request(64, 64);
        // full recurrence, small and wide
        send_request(127, 2);
        send_request(127, 3);
        send_request(10, 3);
        send_request(20, 5);
        send_request(100, 10);
        send_request(85, 21);
        send_request(127, 42);
        send_request(127, 64);
        send_request(127, 126);
        wait_for_results;

        // random traffic under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 66; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 66; end
                default: begin gap_pct = 16; stall_pct = 16; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_request();
            wait_for_results;
        end

        stall_pct = 0;
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
